/* hdl/iatd_pkg.sv */
// ----------------------------------------------------------------------------
// iatd_pkg
// shared types and constants of the averaging tilt detector
// ----------------------------------------------------------------------------
package iatd_pkg;

   // six channels: accel x/y/z then rate x/y/z
   localparam int CHANNELS  = 6;
   localparam int CHAN_BITS = 3;
   localparam logic [CHAN_BITS-1:0] LAST_CHAN  = 3'd5;
   localparam logic [CHAN_BITS-1:0] RATE_FIRST = 3'd3;

   // configuration register widths and reset
   localparam int BIAS_BITS  = 16;
   localparam int LIMIT_BITS = 16;
   localparam logic [LIMIT_BITS-1:0] ROT_LIMIT_RESET = 16'd655;

   // tilt thresholds in raw accel counts
   localparam int TILT_FB_COUNTS = 1426;
   localparam int TILT_LR_COUNTS = 2844;

   // register file map, index = paddr[4:2]
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [2:0] REG_ACCEL_BIAS_X   = 3'd0;
   localparam logic [2:0] REG_ACCEL_BIAS_Y   = 3'd1;
   localparam logic [2:0] REG_ACCEL_BIAS_Z   = 3'd2;
   localparam logic [2:0] REG_RATE_BIAS_X    = 3'd3;
   localparam logic [2:0] REG_RATE_BIAS_Y    = 3'd4;
   localparam logic [2:0] REG_RATE_BIAS_Z    = 3'd5;
   localparam logic [2:0] REG_ROTATION_LIMIT = 3'd6;

   // squaring pass: three rate means then the limit
   localparam logic [1:0] SQ_LIMIT_STEP = 2'd3;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_READ      = 8'b0000_0010,
      ST_SUM       = 8'b0000_0100,
      ST_DIV_START = 8'b0000_1000,
      ST_DIV_WAIT  = 8'b0001_0000,
      ST_MUL       = 8'b0010_0000,
      ST_ACC       = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } state_type;

endpackage

/* hdl/iatd_if.sv */
// ----------------------------------------------------------------------------
// iatd request and response channels
// valid/ready channels carrying one imu sample and one detector result
// ----------------------------------------------------------------------------
interface iatd_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;
   logic signed [SAMPLE_BITS-1:0] rate_x;
   logic signed [SAMPLE_BITS-1:0] rate_y;
   logic signed [SAMPLE_BITS-1:0] rate_z;

   modport source (
      output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
      input  ready
   );
   modport sink (
      input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
      output ready
   );
endinterface

interface iatd_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS:0] mean_accel_x;
   logic signed [SAMPLE_BITS:0] mean_accel_y;
   logic signed [SAMPLE_BITS:0] mean_accel_z;
   logic signed [SAMPLE_BITS:0] mean_rate_x;
   logic signed [SAMPLE_BITS:0] mean_rate_y;
   logic signed [SAMPLE_BITS:0] mean_rate_z;
   logic                        tilt_forward;
   logic                        tilt_backward;
   logic                        tilt_left;
   logic                        tilt_right;
   logic                        tilt_changed;
   logic                        rotation_seen;

   modport source (
      output valid, mean_accel_x, mean_accel_y, mean_accel_z,
             mean_rate_x, mean_rate_y, mean_rate_z,
             tilt_forward, tilt_backward, tilt_left, tilt_right,
             tilt_changed, rotation_seen,
      input  ready
   );
   modport sink (
      input  valid, mean_accel_x, mean_accel_y, mean_accel_z,
             mean_rate_x, mean_rate_y, mean_rate_z,
             tilt_forward, tilt_backward, tilt_left, tilt_right,
             tilt_changed, rotation_seen,
      output ready
   );
endinterface

/* hdl/iatd_divider.sv */
// ----------------------------------------------------------------------------
// iatd_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module iatd_divider #(
   parameter int NUM_BITS = 22,
   parameter int DEN_BITS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});
   assign done  = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_in = {quo_ff[NUM_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule

/* hdl/imu_average_tilt_detector_unit.sv */
// ----------------------------------------------------------------------------
// imu_average_tilt_detector_unit
// moving-average tilt and rotation detector for six-axis imu samples
// ----------------------------------------------------------------------------
// Each request carries one six-axis sample (accel x/y/z, rate x/y/z). The
// per-axis bias registers are subtracted, the corrected value replaces the
// oldest entry of a WINDOW_DEPTH-deep history per channel, and the windowed
// mean (running sum / samples so far, truncated toward zero) of every channel
// is returned together with four tilt flags (x beyond +-1426, y beyond
// +-2844 counts), a tilt-change flag and a rotation flag (sum of squared
// mean rates above rotation_limit squared). From acceptance to a loaded
// response, the six means go one after another through a single bit-serial
// divider (each after a history read, a sum update and a divider start),
// then one shared multiplier squares the three rate means and the limit
// (a multiply and an accumulate step each), then a finish step loads the
// response once the output register is free or being drained. req ready
// is high only while the unit is idle, so a new request cannot be taken
// until the last one has finished; the response sits in an output register
// so the next request can be accepted while it waits. The history is a
// single-port memory; it needs no clearing after reset because entries are
// only read back once the window is full.
module imu_average_tilt_detector_unit
   import iatd_pkg::*;
#(
   parameter int WINDOW_DEPTH = 20,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   iatd_req_if.sink                 req_chan,
   iatd_rsp_if.source               rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);
   // widths derived from the window and sample size
   localparam int MEAN_BITS    = SAMPLE_BITS + 1;
   localparam int CORR_BITS    = ((SAMPLE_BITS > BIAS_BITS) ? SAMPLE_BITS : BIAS_BITS) + 1;
   localparam int MAG_BITS     = CORR_BITS - 1;
   localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_BITS     = CORR_BITS + CNT_BITS;
   localparam int SLOT_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int HIST_ENTRIES = CHANNELS << SLOT_BITS;
   localparam int HADDR_BITS   = CHAN_BITS + SLOT_BITS;
   localparam int PROD_BITS    = 2 * MAG_BITS;
   localparam int ACC_BITS     = PROD_BITS + 2;

   localparam logic [CNT_BITS-1:0]  FULL_COUNT = CNT_BITS'(WINDOW_DEPTH);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(WINDOW_DEPTH - 1);

   localparam logic signed [CORR_BITS-1:0] FB_HI = CORR_BITS'(TILT_FB_COUNTS);
   localparam logic signed [CORR_BITS-1:0] FB_LO = -FB_HI;
   localparam logic signed [CORR_BITS-1:0] LR_HI = CORR_BITS'(TILT_LR_COUNTS);
   localparam logic signed [CORR_BITS-1:0] LR_LO = -LR_HI;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic signed [BIAS_BITS-1:0]  bias_ff [CHANNELS];
   logic        [LIMIT_BITS-1:0] rot_limit_ff;
   logic                         csr_write;
   logic        [2:0]            csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            bias_ff[c] <= '0;
         end
         rot_limit_ff <= ROT_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index) inside
            [REG_ACCEL_BIAS_X:REG_RATE_BIAS_Z]: begin
               bias_ff[csr_index] <= pwdata[BIAS_BITS-1:0];
            end
            REG_ROTATION_LIMIT: begin
               rot_limit_ff <= pwdata[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read back, biases sign extended
   always_comb begin
      case (csr_index) inside
         [REG_ACCEL_BIAS_X:REG_RATE_BIAS_Z]: prdata = CSR_DATA_BITS'(bias_ff[csr_index]);
         REG_ROTATION_LIMIT:                 prdata = CSR_DATA_BITS'(rot_limit_ff);
         default:                            prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // request capture and bias correction
   // ------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] sample [CHANNELS];
   logic signed [CORR_BITS-1:0]   corr_in [CHANNELS];
   logic signed [CORR_BITS-1:0]   corr_ff [CHANNELS];
   logic                          req_fire;

   assign sample[0] = req_chan.accel_x;
   assign sample[1] = req_chan.accel_y;
   assign sample[2] = req_chan.accel_z;
   assign sample[3] = req_chan.rate_x;
   assign sample[4] = req_chan.rate_y;
   assign sample[5] = req_chan.rate_z;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         corr_in[c] = CORR_BITS'(sample[c]) - CORR_BITS'(bias_ff[c]);
      end
   end

   // ------------------------------------------------------------------
   // sequencer state
   // ------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [CHAN_BITS-1:0]    chan_ff, chan_in;
   logic [SLOT_BITS-1:0]    slot_ff, slot_in;
   logic [CNT_BITS-1:0]     fill_ff, fill_in;
   logic                    full_ff, full_in;      // window was full at accept
   logic [1:0]              sq_idx_ff, sq_idx_in;
   logic [3:0]              last_flags_ff, last_flags_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    finish_fire;
   logic [3:0]              flags;                 // right, left, backward, forward

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign finish_fire    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // divider hookup
   logic                  div_start;
   logic                  div_done;
   logic [SUM_BITS-1:0]   div_quo;
   logic [SUM_BITS-1:0]   sum_mag;
   logic signed [SUM_BITS-1:0] sum_sel;
   logic                  sum_neg_ff;
   logic [MAG_BITS-1:0]   quo_mag;
   logic signed [CORR_BITS-1:0] mean_new;

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      full_in       = full_ff;
      sq_idx_in     = sq_idx_ff;
      last_flags_in = last_flags_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
               chan_in  = '0;
               full_in  = (fill_ff == FULL_COUNT);
               if (fill_ff != FULL_COUNT) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_READ:      state_in = ST_SUM;
         ST_SUM:       state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (chan_ff == LAST_CHAN) begin
                  state_in  = ST_MUL;
                  sq_idx_in = '0;
               end else begin
                  state_in = ST_READ;
                  chan_in  = chan_ff + 1'b1;
               end
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (sq_idx_ff == SQ_LIMIT_STEP) begin
               state_in = ST_FINISH;
            end else begin
               state_in  = ST_MUL;
               sq_idx_in = sq_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (finish_fire) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               last_flags_in = flags;
               slot_in       = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chan_ff       <= '0;
         slot_ff       <= '0;
         fill_ff       <= '0;
         full_ff       <= 1'b0;
         sq_idx_ff     <= '0;
         last_flags_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chan_ff       <= chan_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         full_ff       <= full_in;
         sq_idx_ff     <= sq_idx_in;
         last_flags_ff <= last_flags_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // history memory, one row of slots per channel
   // ------------------------------------------------------------------
   logic signed [CORR_BITS-1:0] hist_mem [HIST_ENTRIES];
   logic signed [CORR_BITS-1:0] hist_rd_ff;
   logic        [HADDR_BITS-1:0] hist_addr;
   logic signed [CORR_BITS-1:0] oldest;

   assign hist_addr = {chan_ff, slot_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         hist_rd_ff <= hist_mem[hist_addr];
      end
      if (state_ff == ST_SUM) begin
         hist_mem[hist_addr] <= corr_ff[chan_ff];
      end
   end

   // slots not yet written count as zero while the window fills
   assign oldest = full_ff ? hist_rd_ff : '0;

   // ------------------------------------------------------------------
   // running sums and means
   // ------------------------------------------------------------------
   logic signed [SUM_BITS-1:0]  sums_ff [CHANNELS];
   logic signed [CORR_BITS-1:0] mean_ff [CHANNELS];
   logic        [MAG_BITS-1:0]  rmag_ff [3];

   assign sum_sel   = sums_ff[chan_ff];
   assign sum_mag   = sum_sel[SUM_BITS-1] ? SUM_BITS'(-sum_sel) : SUM_BITS'(sum_sel);
   assign div_start = (state_ff == ST_DIV_START);
   assign quo_mag   = div_quo[MAG_BITS-1:0];
   // magnitude divide then re-sign gives truncation toward zero
   assign mean_new  = sum_neg_ff ? -CORR_BITS'({1'b0, quo_mag}) : CORR_BITS'({1'b0, quo_mag});

   iatd_divider #(
      .NUM_BITS (SUM_BITS),
      .DEN_BITS (CNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sums_ff[c] <= '0;
         end
      end else if (state_ff == ST_SUM) begin
         sums_ff[chan_ff] <= sums_ff[chan_ff] + SUM_BITS'(corr_ff[chan_ff])
                             - SUM_BITS'(oldest);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int c = 0; c < CHANNELS; c++) begin
            corr_ff[c] <= corr_in[c];
         end
      end
      if (div_start) begin
         sum_neg_ff <= sum_sel[SUM_BITS-1];
      end
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         mean_ff[chan_ff] <= mean_new;
         if (chan_ff >= RATE_FIRST) begin
            rmag_ff[2'(chan_ff - RATE_FIRST)] <= quo_mag;
         end
      end
   end

   // ------------------------------------------------------------------
   // shared multiplier: squares of the rate means, then the limit
   // ------------------------------------------------------------------
   logic [MAG_BITS-1:0]  mul_a;
   logic [PROD_BITS-1:0] prod_ff;
   logic [ACC_BITS-1:0]  mag_acc_ff;
   logic [PROD_BITS-1:0] lim_sq_ff;

   assign mul_a = (sq_idx_ff == SQ_LIMIT_STEP) ? MAG_BITS'(rot_limit_ff) : rmag_ff[sq_idx_ff];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mag_acc_ff <= '0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= mul_a * mul_a;
      end
      if (state_ff == ST_ACC) begin
         if (sq_idx_ff == SQ_LIMIT_STEP) begin
            lim_sq_ff <= prod_ff;
         end else begin
            mag_acc_ff <= mag_acc_ff + ACC_BITS'(prod_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // flags and response register
   // ------------------------------------------------------------------
   logic       rotation;

   assign flags[0] = (mean_ff[0] > FB_HI);
   assign flags[1] = (mean_ff[0] < FB_LO);
   assign flags[2] = (mean_ff[1] > LR_HI);
   assign flags[3] = (mean_ff[1] < LR_LO);
   assign rotation = (mag_acc_ff > ACC_BITS'(lim_sq_ff));

   logic signed [MEAN_BITS-1:0] rsp_mean_ff [CHANNELS];
   logic [3:0]                  rsp_flags_ff;
   logic                        rsp_changed_ff;
   logic                        rsp_rotation_ff;

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rsp_mean_ff[c] <= mean_ff[c][MEAN_BITS-1:0];
         end
         rsp_flags_ff    <= flags;
         rsp_changed_ff  <= (flags != last_flags_ff);
         rsp_rotation_ff <= rotation;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mean_accel_x  = rsp_mean_ff[0];
   assign rsp_chan.mean_accel_y  = rsp_mean_ff[1];
   assign rsp_chan.mean_accel_z  = rsp_mean_ff[2];
   assign rsp_chan.mean_rate_x   = rsp_mean_ff[3];
   assign rsp_chan.mean_rate_y   = rsp_mean_ff[4];
   assign rsp_chan.mean_rate_z   = rsp_mean_ff[5];
   assign rsp_chan.tilt_forward  = rsp_flags_ff[0];
   assign rsp_chan.tilt_backward = rsp_flags_ff[1];
   assign rsp_chan.tilt_left     = rsp_flags_ff[2];
   assign rsp_chan.tilt_right    = rsp_flags_ff[3];
   assign rsp_chan.tilt_changed  = rsp_changed_ff;
   assign rsp_chan.rotation_seen = rsp_rotation_ff;

endmodule
